/* src/uts_pkg.sv */
// Shared types and constants of the undo trail stack.
package uts_pkg;

  localparam int DEPTH  = 256;
  localparam int AW     = $clog2(DEPTH);
  localparam int LW     = $clog2(DEPTH + 1);
  localparam int CAP_W  = 9;
  localparam int CW     = (LW > CAP_W) ? LW : CAP_W;
  localparam int DATA_W = 32;
  localparam int KIND_W = 3;
  localparam int ERR_W  = 3;
  localparam int LVL_W  = 9;

  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(256);

  typedef enum logic [KIND_W-1:0] {
    KIND_PUSH     = 3'd0,
    KIND_PUSH_SET = 3'd1,
    KIND_POP      = 3'd2,
    KIND_PURGE    = 3'd3,
    KIND_PEEK     = 3'd4,
    KIND_CLEAR    = 3'd5
  } kind_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_NONE        = 3'd0,
    ERR_OVERFLOW    = 3'd1,
    ERR_UNDERFLOW   = 3'd2,
    ERR_EMPTY_PURGE = 3'd3,
    ERR_EMPTY_PEEK  = 3'd4
  } err_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [DATA_W-1:0]        address;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

/* src/uts_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module uts_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* src/undo_trail_stack.sv */
// Undo trail stack: top level with command decode, cached top entry and result register.
//
// The block keeps a bounded stack of value and address pairs and executes one command per
// item: push, push and set, pop with restore write, purge, peek and clear. Every accepted item
// yields exactly one result item, and the block takes a new item in every clock cycle as long
// as the result register is empty or is being drained in the same cycle, so the sustained rate
// is one item per cycle. The top entry is held in flip-flops; the entry beneath it is read from
// the stack RAM in advance (its read address follows the next fill level) and forwarded
// around the RAM when it was written in the same cycle, so back-to-back pops and purges never
// wait. RAM contents need no clearing after reset: only entries below the fill level are ever
// read, and each of them was written by a push. The capacity register may be written at any
// time the block is idle and takes effect for the next item; values above the RAM depth are
// limited to that depth, and a capacity of zero makes every push overflow.
module undo_trail_stack (
  input  logic                                   clk,
  input  logic                                   rst_n,
  // Capacity register
  input  logic                                   cfg_we,
  input  logic [uts_pkg::CAP_W-1:0]              cfg_wdata,
  // Command items
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [uts_pkg::KIND_W-1:0]             in_kind,
  input  logic signed [uts_pkg::DATA_W-1:0]      in_value,
  input  logic [uts_pkg::DATA_W-1:0]             in_address,
  input  logic signed [uts_pkg::DATA_W-1:0]      in_set_value,
  // Result items
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic                                   out_ok,
  output logic [uts_pkg::ERR_W-1:0]              out_error_code,
  output logic                                   out_write_enable,
  output logic [uts_pkg::DATA_W-1:0]             out_write_address,
  output logic signed [uts_pkg::DATA_W-1:0]      out_write_data,
  output logic signed [uts_pkg::DATA_W-1:0]      out_peek_value,
  output logic [uts_pkg::DATA_W-1:0]             out_peek_address,
  output logic                                   out_empty_res,
  output logic [uts_pkg::LVL_W-1:0]              out_level
);

  // Stack state.
  logic [uts_pkg::LW-1:0]    level_r, level_nxt;
  uts_pkg::err_t             err_r, err_nxt;
  logic [uts_pkg::CAP_W-1:0] cap_r;
  uts_pkg::entry_t           top_r, top_nxt;

  // Forwarding around the RAM when the prefetched entry is written in the same cycle.
  logic                      byp_r, byp_nxt;
  uts_pkg::entry_t           byp_data_r;

  // RAM port signals.
  logic                          ram_we;
  logic [uts_pkg::AW-1:0]        ram_waddr, ram_raddr;
  logic [uts_pkg::ENTRY_W-1:0]   ram_rdata;

  uts_pkg::entry_t           second;
  logic [uts_pkg::LW-1:0]    level_m1, level_nxt_m2;
  logic [uts_pkg::CW-1:0]    level_cmp;
  logic                      push_ok, nonempty, in_acc;

  // Result computed for the accepted item.
  logic                              res_ok, res_we;
  logic [uts_pkg::DATA_W-1:0]        res_waddr, res_paddr;
  logic signed [uts_pkg::DATA_W-1:0] res_wdata, res_pval;

  // Result register.
  logic                              out_valid_r;
  logic                              out_ok_r, out_we_r, out_empty_r;
  uts_pkg::err_t                     out_err_r;
  logic [uts_pkg::DATA_W-1:0]        out_waddr_r, out_paddr_r;
  logic signed [uts_pkg::DATA_W-1:0] out_wdata_r, out_pval_r;
  logic [uts_pkg::LVL_W-1:0]         out_level_r;
  logic [uts_pkg::CW-1:0]            level_nxt_cmp;

  uts_ram #(
    .WIDTH (uts_pkg::ENTRY_W),
    .DEPTH (uts_pkg::DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (top_r),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign in_ready  = !out_valid_r || out_ready;
  assign in_acc    = in_valid && in_ready;

  // The entry just below the top, valid whenever at least two entries are held.
  assign second    = byp_r ? byp_data_r : uts_pkg::entry_t'(ram_rdata);

  assign level_m1  = level_r - uts_pkg::LW'(1);
  assign level_cmp = uts_pkg::CW'(level_r);
  assign nonempty  = (level_r != '0);
  assign push_ok   = (level_cmp < uts_pkg::CW'(cap_r)) &&
                     (level_cmp < uts_pkg::CW'(uts_pkg::DEPTH));

  // The old top moves into the RAM at its own index when a push covers it.
  assign ram_waddr = level_m1[uts_pkg::AW-1:0];

  // Prefetch the entry that will sit beneath the top after this cycle.
  assign level_nxt_m2 = level_nxt - uts_pkg::LW'(2);
  assign ram_raddr    = level_nxt_m2[uts_pkg::AW-1:0];
  assign byp_nxt      = ram_we && (ram_waddr == ram_raddr);

  always_comb begin
    level_nxt = level_r;
    err_nxt   = err_r;
    top_nxt   = top_r;
    ram_we    = 1'b0;
    res_ok    = 1'b0;
    res_we    = 1'b0;
    res_waddr = '0;
    res_wdata = '0;
    res_pval  = '0;
    res_paddr = '0;
    if (in_acc) begin
      case (uts_pkg::kind_t'(in_kind))
        uts_pkg::KIND_PUSH, uts_pkg::KIND_PUSH_SET: begin
          if (push_ok) begin
            ram_we    = nonempty;
            top_nxt   = '{value: in_value, address: in_address};
            level_nxt = level_r + uts_pkg::LW'(1);
            res_ok    = 1'b1;
            if (uts_pkg::kind_t'(in_kind) == uts_pkg::KIND_PUSH_SET) begin
              res_we    = 1'b1;
              res_waddr = in_address;
              res_wdata = in_set_value;
            end
          end else begin
            err_nxt = uts_pkg::ERR_OVERFLOW;
          end
        end
        uts_pkg::KIND_POP: begin
          if (nonempty) begin
            level_nxt = level_m1;
            top_nxt   = second;
            res_ok    = 1'b1;
            res_we    = 1'b1;
            res_waddr = top_r.address;
            res_wdata = top_r.value;
          end else begin
            err_nxt = uts_pkg::ERR_UNDERFLOW;
          end
        end
        uts_pkg::KIND_PURGE: begin
          if (nonempty) begin
            level_nxt = level_m1;
            top_nxt   = second;
            res_ok    = 1'b1;
          end else begin
            err_nxt = uts_pkg::ERR_EMPTY_PURGE;
          end
        end
        uts_pkg::KIND_PEEK: begin
          if (nonempty) begin
            res_ok    = 1'b1;
            res_pval  = top_r.value;
            res_paddr = top_r.address;
          end else begin
            err_nxt = uts_pkg::ERR_EMPTY_PEEK;
          end
        end
        uts_pkg::KIND_CLEAR: begin
          level_nxt = '0;
          err_nxt   = uts_pkg::ERR_NONE;
          res_ok    = 1'b1;
        end
        default: begin
          // Unused command codes leave the state and the sticky error alone.
        end
      endcase
    end
  end

  assign level_nxt_cmp = uts_pkg::CW'(level_nxt);

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r     <= '0;
      err_r       <= uts_pkg::ERR_NONE;
      cap_r       <= uts_pkg::CAP_RESET;
      byp_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      level_r <= level_nxt;
      err_r   <= err_nxt;
      byp_r   <= byp_nxt;
      if (cfg_we) begin
        cap_r <= cfg_wdata;
      end
      if (in_acc) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    top_r      <= top_nxt;
    byp_data_r <= top_r;
    if (in_acc) begin
      out_ok_r    <= res_ok;
      out_err_r   <= err_nxt;
      out_we_r    <= res_we;
      out_waddr_r <= res_waddr;
      out_wdata_r <= res_wdata;
      out_pval_r  <= res_pval;
      out_paddr_r <= res_paddr;
      out_empty_r <= (level_nxt == '0);
      out_level_r <= level_nxt_cmp[uts_pkg::LVL_W-1:0];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_ok            = out_ok_r;
  assign out_error_code    = out_err_r;
  assign out_write_enable  = out_we_r;
  assign out_write_address = out_waddr_r;
  assign out_write_data    = out_wdata_r;
  assign out_peek_value    = out_pval_r;
  assign out_peek_address  = out_paddr_r;
  assign out_empty_res     = out_empty_r;
  assign out_level         = out_level_r;

  // The fill level never passes the RAM depth.
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    uts_pkg::CW'(level_r) <= uts_pkg::CW'(uts_pkg::DEPTH))
    else $error("fill level above stack depth");

  // An accepted clear leaves an empty stack and no sticky error in its result.
  a_clear_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_kind == uts_pkg::KIND_CLEAR) |=>
      out_valid && out_ok && out_empty_res && (out_level == '0) &&
      (out_error_code == uts_pkg::ERR_NONE))
    else $error("clear result not empty and error free");

  // A write request is only issued by a successful command.
  a_write_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_write_enable |-> out_ok)
    else $error("write request from a failed command");

  // A failed command does not move the fill level.
  a_fail_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !res_ok |=> $stable(level_r))
    else $error("failed command changed the fill level");

endmodule

/* dv/uts_tb_pkg.sv */
// Result item type and scoreboard with the command predictor for the undo trail stack bench.
package uts_tb_pkg;

  import uts_pkg::*;

  // Kind codes that the block decodes as no command at all.
  localparam logic [KIND_W-1:0] KIND_SPARE_LO = 3'd6;
  localparam logic [KIND_W-1:0] KIND_SPARE_HI = 3'd7;

  typedef struct packed {
    logic                     ok;
    err_t                     error_code;
    logic                     write_enable;
    logic [DATA_W-1:0]        write_address;
    logic signed [DATA_W-1:0] write_data;
    logic signed [DATA_W-1:0] peek_value;
    logic [DATA_W-1:0]        peek_address;
    logic                     empty_res;
    logic [LVL_W-1:0]         level;
  } outcome_t;

  class trail_scoreboard;
    logic signed [DATA_W-1:0] saved_value [DEPTH];
    logic [DATA_W-1:0]        saved_address [DEPTH];
    int unsigned              fill;
    err_t                     last_err;
    logic [CAP_W-1:0]         capacity;
    outcome_t                 outcomes_due [$];
    int                       failures;

    function new();
      fill     = 0;
      last_err = ERR_NONE;
      capacity = CAP_RESET;
      failures = 0;
    endfunction

    function void set_capacity(logic [CAP_W-1:0] c);
      capacity = c;
    endfunction

    function int pending();
      return outcomes_due.size();
    endfunction

    // Applies one accepted command to the stack copy and queues the result it should give.
    function void note_command(logic [KIND_W-1:0] kind, logic signed [DATA_W-1:0] value,
                               logic [DATA_W-1:0] address, logic signed [DATA_W-1:0] set_value);
      outcome_t    o;
      int unsigned limit;
      o = '0;
      limit = (capacity > DEPTH) ? DEPTH : capacity;
      case (kind)
        KIND_PUSH, KIND_PUSH_SET: begin
          if (fill < limit) begin
            saved_value[fill]   = value;
            saved_address[fill] = address;
            fill++;
            o.ok = 1'b1;
            if (kind == KIND_PUSH_SET) begin
              o.write_enable  = 1'b1;
              o.write_address = address;
              o.write_data    = set_value;
            end
          end else begin
            last_err = ERR_OVERFLOW;
          end
        end
        KIND_POP: begin
          if (fill > 0) begin
            fill--;
            o.ok            = 1'b1;
            o.write_enable  = 1'b1;
            o.write_address = saved_address[fill];
            o.write_data    = saved_value[fill];
          end else begin
            last_err = ERR_UNDERFLOW;
          end
        end
        KIND_PURGE: begin
          if (fill > 0) begin
            fill--;
            o.ok = 1'b1;
          end else begin
            last_err = ERR_EMPTY_PURGE;
          end
        end
        KIND_PEEK: begin
          if (fill > 0) begin
            o.ok           = 1'b1;
            o.peek_value   = saved_value[fill-1];
            o.peek_address = saved_address[fill-1];
          end else begin
            last_err = ERR_EMPTY_PEEK;
          end
        end
        KIND_CLEAR: begin
          fill     = 0;
          last_err = ERR_NONE;
          o.ok     = 1'b1;
        end
        default: ;
      endcase
      o.error_code = last_err;
      o.empty_res  = (fill == 0);
      o.level      = LVL_W'(fill);
      outcomes_due.push_back(o);
    endfunction

    function void check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got,
                              longint stamp);
      if (want !== got) begin
        failures++;
        $display("%0d ns: %s expected %0h actual %0h", stamp, name, want, got);
      end
    endfunction

    // Compares one result item with the oldest queued one.
    function void check_outcome(outcome_t got, longint stamp);
      outcome_t want;
      if (outcomes_due.size() == 0) begin
        failures++;
        $display("%0d ns: result item with no command pending, expected none actual %0h",
                 stamp, got);
        return;
      end
      want = outcomes_due.pop_front();
      check_field("ok", want.ok, got.ok, stamp);
      check_field("error_code", want.error_code, got.error_code, stamp);
      check_field("write_enable", want.write_enable, got.write_enable, stamp);
      check_field("write_address", want.write_address, got.write_address, stamp);
      check_field("write_data", want.write_data, got.write_data, stamp);
      check_field("peek_value", want.peek_value, got.peek_value, stamp);
      check_field("peek_address", want.peek_address, got.peek_address, stamp);
      check_field("empty_res", want.empty_res, got.empty_res, stamp);
      check_field("level", want.level, got.level, stamp);
    endfunction
  endclass

endpackage

/* dv/tb_undo_trail_stack.sv */
// Testbench top: drives commands and capacity writes into the undo trail stack and checks results.
module tb_undo_trail_stack;

  timeunit 1ns;
  timeprecision 1ps;

  import uts_pkg::*;
  import uts_tb_pkg::*;

  // Watchdog bound in clock cycles. The slowest legal run is about 500 items, each waiting
  // out the longest sender gap and the longest receiver stall, plus one long hold-off.
  localparam int LIMIT_CYCLES = 200000;
  // Length of the receiver hold-off that backs the block up into its input.
  localparam int HOLD_CYCLES  = 60;

  logic clk = 1'b0;
  logic rst_n;

  logic                     cfg_we;
  logic [CAP_W-1:0]         cfg_wdata;
  logic                     in_valid;
  logic                     in_ready;
  logic [KIND_W-1:0]        in_kind;
  logic signed [DATA_W-1:0] in_value;
  logic [DATA_W-1:0]        in_address;
  logic signed [DATA_W-1:0] in_set_value;
  logic                     out_valid;
  logic                     out_ready;
  logic                     out_ok;
  logic [ERR_W-1:0]         out_error_code;
  logic                     out_write_enable;
  logic [DATA_W-1:0]        out_write_address;
  logic signed [DATA_W-1:0] out_write_data;
  logic signed [DATA_W-1:0] out_peek_value;
  logic [DATA_W-1:0]        out_peek_address;
  logic                     out_empty_res;
  logic [LVL_W-1:0]         out_level;

  trail_scoreboard sb;

  // The stimulus process raises this to ask the receiver for one long hold-off.
  bit hold_req;
  // While set, the sender offers items back to back with no gaps.
  bit no_gaps;

  undo_trail_stack uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_kind           (in_kind),
    .in_value          (in_value),
    .in_address        (in_address),
    .in_set_value      (in_set_value),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_ok            (out_ok),
    .out_error_code    (out_error_code),
    .out_write_enable  (out_write_enable),
    .out_write_address (out_write_address),
    .out_write_data    (out_write_data),
    .out_peek_value    (out_peek_value),
    .out_peek_address  (out_peek_address),
    .out_empty_res     (out_empty_res),
    .out_level         (out_level)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Both monitors sample at the rising edge. All testbench drives are nonblocking, so what
  // they see here is the value that was present just before the edge.
  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      sb.note_command(in_kind, in_value, in_address, in_set_value);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_outcome(outcome_t'{ok: out_ok, error_code: err_t'(out_error_code),
                                  write_enable: out_write_enable,
                                  write_address: out_write_address,
                                  write_data: out_write_data, peek_value: out_peek_value,
                                  peek_address: out_peek_address, empty_res: out_empty_res,
                                  level: out_level}, $time);
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < LIMIT_CYCLES) begin
      @(posedge clk);
      cycles++;
    end
    $display("FAIL");
    $finish;
  end

  // Result receiver. Mostly ready, with short stalls, a few long ones, calm stretches with
  // no stalls at all, and the one long hold-off that the stimulus asks for.
  initial begin : sink
    int stall_left;
    int calm_left;
    int hold_left;
    int r;
    bit hold_done;
    stall_left = 0;
    calm_left  = 0;
    hold_left  = 0;
    hold_done  = 1'b0;
    out_ready  = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready <= 1'b0;
      end else if (calm_left > 0) begin
        calm_left--;
        out_ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          calm_left = $urandom_range(20, 60);
          out_ready <= 1'b1;
        end else if (r < 60) begin
          out_ready <= 1'b1;
        end else if (r < 94) begin
          stall_left = $urandom_range(0, 2);
          out_ready <= 1'b0;
        end else begin
          stall_left = $urandom_range(8, 24);
          out_ready <= 1'b0;
        end
      end
    end
  end

  // Sender gap length: usually none, sometimes a few cycles, now and then a long pause.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end else if (r < 88) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 24);
  endfunction

  // Data word biased toward the signed and unsigned extremes.
  function automatic logic [DATA_W-1:0] pick_word();
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'h0000_0000;
      3: return 32'hFFFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  // Offers one command item and returns at the edge where it is taken. Valid stays high
  // when the next item follows with no gap, so it is never dropped and raised in one step.
  task automatic offer(input logic [KIND_W-1:0] kind, input logic [DATA_W-1:0] value,
                       input logic [DATA_W-1:0] address, input logic [DATA_W-1:0] set_value);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_kind      <= kind;
    in_value     <= value;
    in_address   <= address;
    in_set_value <= set_value;
    do @(posedge clk); while (!in_ready);
  endtask

  // Random command. push_pct sets how often a push of either kind is chosen; the rest is
  // mostly pops, purges and peeks, with a rare clear and a rare unused kind.
  task automatic offer_random(input int push_pct);
    logic [KIND_W-1:0] kind;
    int                r;
    r = $urandom_range(0, 99);
    if (r < push_pct) begin
      kind = ($urandom_range(0, 1) != 0) ? KIND_PUSH_SET : KIND_PUSH;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 43) begin
        kind = KIND_POP;
      end else if (r < 68) begin
        kind = KIND_PURGE;
      end else if (r < 94) begin
        kind = KIND_PEEK;
      end else if (r < 97) begin
        kind = KIND_CLEAR;
      end else begin
        kind = ($urandom_range(0, 1) != 0) ? KIND_SPARE_HI : KIND_SPARE_LO;
      end
    end
    offer(kind, pick_word(), pick_word(), pick_word());
  endtask

  // Drops valid and waits until every queued result has come back and the result register
  // is surely empty.
  task automatic settle_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  // Capacity writes happen only with the block idle; the new limit applies to the next item.
  task automatic write_capacity(input logic [CAP_W-1:0] c);
    settle_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= c;
    @(posedge clk);
    cfg_we    <= 1'b0;
    sb.set_capacity(c);
  endtask

  initial begin : stimulus
    sb           = new();
    rst_n        = 1'b0;
    cfg_we       = 1'b0;
    cfg_wdata    = '0;
    in_valid     = 1'b0;
    in_kind      = KIND_PUSH;
    in_value     = '0;
    in_address   = '0;
    in_set_value = '0;
    hold_req     = 1'b0;
    no_gaps      = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part. An empty stack must reject peek, pop and purge, each failure replacing
    // the sticky code; unused kinds change nothing; clear wipes the error.
    offer(KIND_PEEK, 32'h0, 32'h0, 32'h0);
    offer(KIND_POP, 32'h0, 32'h0, 32'h0);
    offer(KIND_PURGE, 32'h0, 32'h0, 32'h0);
    offer(KIND_SPARE_LO, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    offer(KIND_SPARE_HI, 32'h0, 32'h0, 32'h0);
    offer(KIND_CLEAR, 32'h0, 32'h0, 32'h0);
    // Field extremes, a push and set aimed at address zero, then pops that restore them,
    // the last one writing back to address zero.
    offer(KIND_PUSH, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h8000_0000);
    offer(KIND_PUSH_SET, 32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFF);
    offer(KIND_PUSH_SET, 32'hFFFF_FFFF, 32'h1234_5678, 32'h8000_0000);
    offer(KIND_PEEK, 32'h0, 32'h0, 32'h0);
    offer(KIND_POP, 32'h0, 32'h0, 32'h0);
    offer(KIND_POP, 32'h0, 32'h0, 32'h0);
    offer(KIND_PUSH, 32'h0, 32'h0, 32'h0);
    offer(KIND_PURGE, 32'h0, 32'h0, 32'h0);
    offer(KIND_PEEK, 32'h0, 32'h0, 32'h0);
    // A capacity of zero turns every push into an overflow, and a push and set that fails
    // must not request its write.
    write_capacity(9'd0);
    offer(KIND_PUSH_SET, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
    // Capacity of one with one entry still held: both pushes overflow, then a pop, then an underflow that replaces
    // the overflow code.
    write_capacity(9'd1);
    offer(KIND_PUSH, 32'hAAAA_AAAA, 32'h5555_5555, 32'h0);
    offer(KIND_PUSH_SET, 32'h1, 32'h2, 32'h3);
    offer(KIND_POP, 32'h0, 32'h0, 32'h0);
    offer(KIND_POP, 32'h0, 32'h0, 32'h0);
    // Capacity lowered below the level: pushes overflow while peek, pop and purge still
    // work on what is held.
    write_capacity(CAP_RESET);
    offer(KIND_PUSH, 32'h1111_1111, 32'h2222_2222, 32'h0);
    offer(KIND_PUSH, 32'h3333_3333, 32'h4444_4444, 32'h0);
    offer(KIND_PUSH, 32'h5555_5555, 32'h6666_6666, 32'h0);
    write_capacity(9'd1);
    offer(KIND_PUSH, 32'h7777_7777, 32'h8888_8888, 32'h0);
    offer(KIND_PEEK, 32'h0, 32'h0, 32'h0);
    offer(KIND_POP, 32'h0, 32'h0, 32'h0);
    offer(KIND_PURGE, 32'h0, 32'h0, 32'h0);
    offer(KIND_CLEAR, 32'h0, 32'h0, 32'h0);

    // Random part. A tiny capacity keeps overflows and underflows frequent.
    write_capacity(9'd3);
    repeat (50) offer_random(50);

    // Push-heavy traffic builds up a deep stack.
    write_capacity(9'd40);
    repeat (60) offer_random(72);

    // Capacity drops under the level built above. The sender goes back to back while the
    // receiver holds off for a long stretch, so the block fills and stalls its input.
    write_capacity(9'd5);
    no_gaps  = 1'b1;
    hold_req = 1'b1;
    repeat (30) offer_random(45);
    no_gaps = 1'b0;

    // All-ones capacity is limited to the RAM depth: fill every entry with random content,
    // overflow once more, then mix.
    write_capacity(9'h1FF);
    offer(KIND_CLEAR, 32'h0, 32'h0, 32'h0);
    repeat (DEPTH + 1) begin
      offer(($urandom_range(0, 1) != 0) ? KIND_PUSH_SET : KIND_PUSH, pick_word(),
            pick_word(), pick_word());
    end
    offer(KIND_PEEK, 32'h0, 32'h0, 32'h0);
    repeat (20) offer_random(30);

    // Back to the reset capacity, then a closing stretch with capacity zero.
    write_capacity(CAP_RESET);
    repeat (30) offer_random(40);
    write_capacity(9'd0);
    repeat (10) offer_random(50);

    settle_idle();
    if (sb.failures == 0 && sb.pending() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
